// File: rtl/trip1_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trip1_pkg
// Shared widths, codes and stage types of the P1 triangle gradients pipeline.
// ----------------------------------------------------------------------------
package trip1_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 24;

    // Port widths of the fields.
    localparam int IN_W     = 16;
    localparam int THRESH_W = 34;
    localparam int AREA_W   = 35;
    localparam int GRAD_W   = 42;

    localparam int LANES  = 6;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int D_W    = PROD_W + 1;
    localparam int MAG_W  = 2 * COORD_BITS + 2;
    localparam int NUM_W  = COORD_BITS;
    localparam int DVD_W  = NUM_W + FRAC_BITS;
    localparam int CMP_W  = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;

    localparam logic [1:0] ORIENT_CCW   = 2'd0;
    localparam logic [1:0] ORIENT_CW    = 2'd1;
    localparam logic [1:0] ORIENT_DEGEN = 2'd2;

    typedef struct packed {
        logic [1:0]              orient;
        logic                    degen;
        logic signed [D_W-1:0]   area;
        logic [LANES-1:0]        neg;
    } meta_t;

    typedef struct packed {
        logic                              valid;
        meta_t                             meta;
        logic [MAG_W-1:0]                  divisor;
        logic [LANES-1:0][NUM_W-1:0]       num;
    } div_in_t;

    typedef struct packed {
        logic                              valid;
        meta_t                             meta;
        logic [LANES-1:0][DVD_W-1:0]       quo;
    } div_out_t;

endpackage
`default_nettype wire

// File: rtl/trip1_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trip1_front
// Differences, cross product, classification and operand magnitudes.
// ----------------------------------------------------------------------------
module trip1_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic [trip1_pkg::IN_W-1:0]    ax,
    input  wire logic [trip1_pkg::IN_W-1:0]    ay,
    input  wire logic [trip1_pkg::IN_W-1:0]    bx,
    input  wire logic [trip1_pkg::IN_W-1:0]    by,
    input  wire logic [trip1_pkg::IN_W-1:0]    cx,
    input  wire logic [trip1_pkg::IN_W-1:0]    cy,
    input  wire logic [trip1_pkg::THRESH_W-1:0] thresh,
    output trip1_pkg::div_in_t                 div_in
);
    import trip1_pkg::*;

    logic signed [DIFF_W-1:0] sax, say, sbx, sby, scx, scy;

    // stage 1: edge differences
    logic                                 v1_reg;
    logic signed [DIFF_W-1:0]             e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [LANES-1:0][DIFF_W-1:0]  g1_reg;
    // stage 2: products
    logic                                 v2_reg;
    logic signed [PROD_W-1:0]             p1_reg, p2_reg;
    logic signed [LANES-1:0][DIFF_W-1:0]  g2_reg;
    // stage 3: cross product
    logic                                 v3_reg;
    logic signed [D_W-1:0]                d3_reg;
    logic signed [LANES-1:0][DIFF_W-1:0]  g3_reg;
    // stage 4: classification
    div_in_t                              s4_reg;

    logic signed [D_W-1:0]        d_neg;
    logic [MAG_W-1:0]             mag;
    logic                         degen;
    div_in_t                      s4_next;
    logic signed [DIFF_W-1:0]     gn;

    assign sax = DIFF_W'($signed(ax[COORD_BITS-1:0]));
    assign say = DIFF_W'($signed(ay[COORD_BITS-1:0]));
    assign sbx = DIFF_W'($signed(bx[COORD_BITS-1:0]));
    assign sby = DIFF_W'($signed(by[COORD_BITS-1:0]));
    assign scx = DIFF_W'($signed(cx[COORD_BITS-1:0]));
    assign scy = DIFF_W'($signed(cy[COORD_BITS-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            s4_reg.valid <= 1'b0;
        end else if (adv) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            s4_reg.valid <= s4_next.valid;
        end
        if (adv) begin
            e1x_reg   <= sbx - sax;
            e1y_reg   <= scy - say;
            e2x_reg   <= scx - sax;
            e2y_reg   <= sby - say;
            g1_reg[0] <= sby - scy;
            g1_reg[1] <= scx - sbx;
            g1_reg[2] <= scy - say;
            g1_reg[3] <= sax - scx;
            g1_reg[4] <= say - sby;
            g1_reg[5] <= sbx - sax;
            p1_reg    <= e1x_reg * e1y_reg;
            p2_reg    <= e2x_reg * e2y_reg;
            g2_reg    <= g1_reg;
            d3_reg    <= D_W'(p1_reg) - D_W'(p2_reg);
            g3_reg    <= g2_reg;
            s4_reg.meta    <= s4_next.meta;
            s4_reg.divisor <= s4_next.divisor;
            s4_reg.num     <= s4_next.num;
        end
    end

    always_comb begin
        d_neg = -d3_reg;
        mag   = d3_reg[D_W-1] ? MAG_W'(d_neg) : MAG_W'(d3_reg);
        degen = CMP_W'(mag) <= CMP_W'(thresh);
        s4_next = '0;
        s4_next.valid       = v3_reg;
        s4_next.meta.degen  = degen;
        s4_next.meta.area   = d3_reg;
        s4_next.meta.orient = degen ? ORIENT_DEGEN :
                              (d3_reg[D_W-1] ? ORIENT_CW : ORIENT_CCW);
        s4_next.divisor     = mag;
        for (int l = 0; l < LANES; l++) begin
            gn = -g3_reg[l];
            s4_next.num[l]      = g3_reg[l][DIFF_W-1] ? NUM_W'(gn) : NUM_W'(g3_reg[l]);
            s4_next.meta.neg[l] = g3_reg[l][DIFF_W-1] ^ d3_reg[D_W-1];
        end
    end

    assign div_in = s4_reg;

endmodule
`default_nettype wire

// File: rtl/trip1_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trip1_divider
// Restoring divider, one quotient bit per stage, six lanes sharing a divisor.
// ----------------------------------------------------------------------------
module trip1_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire trip1_pkg::div_in_t  div_in,
    output trip1_pkg::div_out_t div_out
);
    import trip1_pkg::*;

    logic [DVD_W-1:0]              vld_reg;
    meta_t                         meta_reg [DVD_W];
    logic [MAG_W-1:0]              dsr_reg  [DVD_W];
    logic [LANES-1:0][MAG_W-1:0]   rem_reg  [DVD_W];
    logic [LANES-1:0][DVD_W-1:0]   sh_reg   [DVD_W];

    logic [LANES-1:0][MAG_W-1:0]   rem_next [DVD_W];
    logic [LANES-1:0][DVD_W-1:0]   sh_next  [DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        logic                          v_in;
        meta_t                         m_in;
        logic [MAG_W-1:0]              d_in;
        logic [LANES-1:0][MAG_W-1:0]   r_in;
        logic [LANES-1:0][DVD_W-1:0]   s_in;

        if (k == 0) begin : g_first
            assign v_in = div_in.valid;
            assign m_in = div_in.meta;
            assign d_in = div_in.divisor;
            assign r_in = '0;
            for (genvar l = 0; l < LANES; l++) begin : g_load
                assign s_in[l] = {div_in.num[l], {FRAC_BITS{1'b0}}};
            end
        end else begin : g_rest
            assign v_in = vld_reg[k-1];
            assign m_in = meta_reg[k-1];
            assign d_in = dsr_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign s_in = sh_reg[k-1];
        end

        always_comb begin
            logic [MAG_W:0] trial;
            logic           qbit;
            for (int l = 0; l < LANES; l++) begin
                trial = {r_in[l], s_in[l][DVD_W-1]};
                qbit  = trial >= {1'b0, d_in};
                rem_next[k][l] = qbit ? MAG_W'(trial - {1'b0, d_in}) : MAG_W'(trial);
                sh_next[k][l]  = {s_in[l][DVD_W-2:0], qbit};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= v_in;
            end
            if (adv) begin
                meta_reg[k] <= m_in;
                dsr_reg[k]  <= d_in;
                rem_reg[k]  <= rem_next[k];
                sh_reg[k]   <= sh_next[k];
            end
        end
    end

    assign div_out.valid = vld_reg[DVD_W-1];
    assign div_out.meta  = meta_reg[DVD_W-1];
    assign div_out.quo   = sh_reg[DVD_W-1];

endmodule
`default_nettype wire

// File: rtl/triangle_p1_gradients_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_p1_gradients_unit
// Twice signed area, orientation and P1 shape-function gradients of a triangle.
// ----------------------------------------------------------------------------
// One triangle item is taken per cycle while the pipeline is not held. Its path
// runs through a register each for edge differences, products, the cross
// product, and the degenerate test with operand magnitudes, then the
// restoring divider (one quotient bit per stage, 16 + 24 bits) and one output
// register that applies the signs. The whole pipeline holds while a result
// waits on m_ready, so s_ready is low exactly when the output register is full
// and not being taken. Gradients are truncated toward zero; a triangle whose
// |twice area| is at or below the threshold reports degenerate with zero
// gradients. Write the threshold through cfg_* only while the block is idle.
// ----------------------------------------------------------------------------
module triangle_p1_gradients_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [trip1_pkg::THRESH_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire logic [trip1_pkg::IN_W-1:0]      s_vertex_a_x,
    input  wire logic [trip1_pkg::IN_W-1:0]      s_vertex_a_y,
    input  wire logic [trip1_pkg::IN_W-1:0]      s_vertex_b_x,
    input  wire logic [trip1_pkg::IN_W-1:0]      s_vertex_b_y,
    input  wire logic [trip1_pkg::IN_W-1:0]      s_vertex_c_x,
    input  wire logic [trip1_pkg::IN_W-1:0]      s_vertex_c_y,
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      logic [1:0]                      m_orientation_code,
    output      logic [trip1_pkg::AREA_W-1:0]    m_twice_signed_area,
    output      logic [trip1_pkg::GRAD_W-1:0]    m_grad_a_x,
    output      logic [trip1_pkg::GRAD_W-1:0]    m_grad_a_y,
    output      logic [trip1_pkg::GRAD_W-1:0]    m_grad_b_x,
    output      logic [trip1_pkg::GRAD_W-1:0]    m_grad_b_y,
    output      logic [trip1_pkg::GRAD_W-1:0]    m_grad_c_x,
    output      logic [trip1_pkg::GRAD_W-1:0]    m_grad_c_y
);
    import trip1_pkg::*;

    logic [THRESH_W-1:0]          thresh_reg;
    logic                         adv;
    div_in_t                      div_in;
    div_out_t                     div_out;
    logic                         out_valid_reg;
    logic [1:0]                   orient_reg;
    logic [AREA_W-1:0]            area_reg;
    logic [LANES-1:0][GRAD_W-1:0] grad_reg;
    logic [LANES-1:0][GRAD_W-1:0] grad_next;

    // Threshold register; always ready. The user must write it only while idle; the block does not enforce this.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= '0;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    // Advance every stage unless a result is held at the output.
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    trip1_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .ax       (s_vertex_a_x),
        .ay       (s_vertex_a_y),
        .bx       (s_vertex_b_x),
        .by       (s_vertex_b_y),
        .cx       (s_vertex_c_x),
        .cy       (s_vertex_c_y),
        .thresh   (thresh_reg),
        .div_in   (div_in)
    );

    trip1_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .div_in  (div_in),
        .div_out (div_out)
    );

    // Apply quotient signs; drop gradients of a degenerate triangle.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (div_out.meta.degen) begin
                grad_next[l] = '0;
            end else if (div_out.meta.neg[l]) begin
                grad_next[l] = -GRAD_W'(div_out.quo[l]);
            end else begin
                grad_next[l] = GRAD_W'(div_out.quo[l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= div_out.valid;
        end
        if (adv) begin
            orient_reg <= div_out.meta.orient;
            area_reg   <= AREA_W'(div_out.meta.area);
            grad_reg   <= grad_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_orientation_code  = orient_reg;
    assign m_twice_signed_area = area_reg;
    assign m_grad_a_x          = grad_reg[0];
    assign m_grad_a_y          = grad_reg[1];
    assign m_grad_b_x          = grad_reg[2];
    assign m_grad_b_y          = grad_reg[3];
    assign m_grad_c_x          = grad_reg[4];
    assign m_grad_c_y          = grad_reg[5];

endmodule
`default_nettype wire

// File: rtl/trip1_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trip1_checker
// Port-level checks of the triangle gradients unit, bound to its top level.
// ----------------------------------------------------------------------------
module trip1_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [1:0]                      m_orientation_code,
    input wire logic [trip1_pkg::AREA_W-1:0]    m_twice_signed_area,
    input wire logic [trip1_pkg::GRAD_W-1:0]    m_grad_a_x,
    input wire logic [trip1_pkg::GRAD_W-1:0]    m_grad_a_y,
    input wire logic [trip1_pkg::GRAD_W-1:0]    m_grad_b_x,
    input wire logic [trip1_pkg::GRAD_W-1:0]    m_grad_b_y,
    input wire logic [trip1_pkg::GRAD_W-1:0]    m_grad_c_x,
    input wire logic [trip1_pkg::GRAD_W-1:0]    m_grad_c_y
);
    import trip1_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_twice_signed_area)
            && $stable(m_orientation_code) && $stable(m_grad_a_x))
        else $error("result item changed while stalled");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_orientation_code == ORIENT_DEGEN |->
            m_grad_a_x == '0 && m_grad_a_y == '0 && m_grad_b_x == '0 &&
            m_grad_b_y == '0 && m_grad_c_x == '0 && m_grad_c_y == '0)
        else $error("degenerate triangle with nonzero gradient");

    a_ccw_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_orientation_code == ORIENT_CCW |->
            !m_twice_signed_area[AREA_W-1] && m_twice_signed_area != '0)
        else $error("counter-clockwise code with non-positive area");

    a_cw_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_orientation_code == ORIENT_CW |-> m_twice_signed_area[AREA_W-1])
        else $error("clockwise code with non-negative area");

endmodule

bind triangle_p1_gradients_unit trip1_checker u_trip1_checker (.*);
`default_nettype wire

// File: test/tb_triangle_p1_gradients_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_p1_gradients_unit
// Streams triangles through the gradients pipeline under several degenerate
// thresholds, with random gaps and stalls on both sides. A scoreboard class
// predicts twice the area, the orientation and the six fixed-point gradients
// of every accepted triangle and checks each result item in order.
// ----------------------------------------------------------------------------
module tb_triangle_p1_gradients_unit;
    import trip1_pkg::*;

    localparam int PIPE_LATENCY = 45;

    typedef struct {
        logic [1:0]        orient;
        logic [AREA_W-1:0] area;
        logic [GRAD_W-1:0] grad [LANES];
    } gradient_result_t;

    // Gradient predictor plus the queue of pending results.
    class gradient_scoreboard;
        gradient_result_t pending[$];
        logic [THRESH_W-1:0] threshold;
        int errors;
        int checked;
        int n_ccw, n_cw, n_degen;

        function new();
            threshold = '0;
            errors = 0;
            checked = 0;
            n_ccw = 0;
            n_cw = 0;
            n_degen = 0;
        endfunction

        // (num * 2^FRAC_BITS) / den, truncated toward zero
        function longint scaled_quotient(longint num, longint den);
            longint un;
            longint ud;
            longint q;
            un = (num < 0) ? -num : num;
            ud = (den < 0) ? -den : den;
            q = (un <<< FRAC_BITS) / ud;
            return ((num < 0) != (den < 0)) ? -q : q;
        endfunction

        function void note_triangle(logic [IN_W-1:0] v [6]);
            longint c [6];
            longint d;
            longint mag;
            longint g [6];
            gradient_result_t r;
            for (int i = 0; i < 6; i++) begin
                c[i] = longint'($signed(v[i][COORD_BITS-1:0]));
                g[i] = 0;
            end
            // c: ax ay bx by cx cy
            d = (c[2] - c[0]) * (c[5] - c[1]) - (c[4] - c[0]) * (c[3] - c[1]);
            mag = (d < 0) ? -d : d;
            if (mag <= longint'({30'd0, threshold})) begin
                r.orient = ORIENT_DEGEN;
            end else begin
                r.orient = (d > 0) ? ORIENT_CCW : ORIENT_CW;
                g[0] = scaled_quotient(c[3] - c[5], d);
                g[1] = scaled_quotient(c[4] - c[2], d);
                g[2] = scaled_quotient(c[5] - c[1], d);
                g[3] = scaled_quotient(c[0] - c[4], d);
                g[4] = scaled_quotient(c[1] - c[3], d);
                g[5] = scaled_quotient(c[2] - c[0], d);
            end
            r.area = d[AREA_W-1:0];
            for (int i = 0; i < 6; i++) r.grad[i] = g[i][GRAD_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(gradient_result_t act);
            gradient_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result item, orient %0d area %0h",
                         $time, act.orient, act.area);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            case (exp_r.orient)
                ORIENT_CCW: n_ccw++;
                ORIENT_CW:  n_cw++;
                default:    n_degen++;
            endcase
            if (act.orient !== exp_r.orient) begin
                $display("%0t: orientation expected %0d actual %0d",
                         $time, exp_r.orient, act.orient);
                errors++;
            end
            if (act.area !== exp_r.area) begin
                $display("%0t: twice area expected %0h actual %0h",
                         $time, exp_r.area, act.area);
                errors++;
            end
            for (int i = 0; i < LANES; i++) begin
                if (act.grad[i] !== exp_r.grad[i]) begin
                    $display("%0t: gradient %0d expected %0h actual %0h",
                             $time, i, exp_r.grad[i], act.grad[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [THRESH_W-1:0]   cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_W-1:0]       s_vertex [6];
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_orientation_code;
    logic [AREA_W-1:0]     m_twice_signed_area;
    logic [GRAD_W-1:0]     m_grad [LANES];

    gradient_scoreboard sb;
    bit  idle_on;        // random gaps and stalls enabled
    int  rx_hold;        // long receiver hold-off, in cycles
    int  rx_gap;

    triangle_p1_gradients_unit dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_vertex_a_x        (s_vertex[0]),
        .s_vertex_a_y        (s_vertex[1]),
        .s_vertex_b_x        (s_vertex[2]),
        .s_vertex_b_y        (s_vertex[3]),
        .s_vertex_c_x        (s_vertex[4]),
        .s_vertex_c_y        (s_vertex[5]),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_orientation_code  (m_orientation_code),
        .m_twice_signed_area (m_twice_signed_area),
        .m_grad_a_x          (m_grad[0]),
        .m_grad_a_y          (m_grad[1]),
        .m_grad_b_x          (m_grad[2]),
        .m_grad_b_y          (m_grad[3]),
        .m_grad_c_x          (m_grad[4]),
        .m_grad_c_y          (m_grad[5])
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Give up after a generous fixed time.
    initial begin
        #2ms;
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("FAIL");
        $finish;
    end

    // Receiver: decide m_ready at the falling edge.
    initial begin
        m_ready = 1'b0;
        rx_gap = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready = 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                m_ready = 1'b0;
                rx_gap--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                rx_gap = $urandom_range(0, 14);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Check each result item at the rising edge it is taken.
    always @(posedge aclk) begin
        gradient_result_t act;
        if (aresetn && m_valid && m_ready) begin
            act.orient = m_orientation_code;
            act.area = m_twice_signed_area;
            for (int i = 0; i < LANES; i++) act.grad[i] = m_grad[i];
            sb.check_result(act);
        end
    end

    // Offer one triangle; hold it until accepted.
    task automatic send_triangle(logic [IN_W-1:0] v [6]);
        @(negedge aclk);
        s_vertex = v;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_triangle(v);
    endtask

    task automatic sender_gap(int n);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Drop valid and wait until every result is back plus pipeline slack.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [THRESH_W-1:0] value);
        @(negedge aclk);
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.threshold = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [IN_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    // Full-range triangles half of the time, plus tiny, collinear, repeated-vertex and
    // extreme-corner ones so thresholds and the degenerate path get exercised.
    task automatic random_triangles(int count);
        logic [IN_W-1:0] v [6];
        logic [IN_W-1:0] dx, dy;
        int k;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    for (int i = 0; i < 6; i++) v[i] = $urandom();
                end
                5, 6: begin
                    v[0] = $urandom();
                    v[1] = $urandom();
                    for (int i = 2; i < 6; i++)
                        v[i] = v[i & 1] + IN_W'($urandom_range(0, 32)) - 16'd16;
                end
                7: begin
                    v[0] = $urandom();
                    v[1] = $urandom();
                    dx = IN_W'($urandom_range(0, 200)) - 16'd100;
                    dy = IN_W'($urandom_range(0, 200)) - 16'd100;
                    k = $urandom_range(1, 50);
                    v[2] = v[0] + dx;
                    v[3] = v[1] + dy;
                    v[4] = v[0] - dx * IN_W'(k);
                    v[5] = v[1] - dy * IN_W'(k);
                end
                8: begin
                    for (int i = 0; i < 6; i++) v[i] = $urandom();
                    v[4] = v[0];
                    v[5] = v[1];
                end
                default: begin
                    for (int i = 0; i < 6; i++) v[i] = pick_extreme();
                end
            endcase
            send_triangle(v);
            if (idle_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 15));
        end
    endtask

    task automatic directed_triangle(int ax, int ay, int bx, int by, int cx, int cy);
        logic [IN_W-1:0] v [6];
        v[0] = IN_W'(ax);
        v[1] = IN_W'(ay);
        v[2] = IN_W'(bx);
        v[3] = IN_W'(by);
        v[4] = IN_W'(cx);
        v[5] = IN_W'(cy);
        send_triangle(v);
    endtask

    initial begin
        sb = new();
        idle_on = 1'b0;
        rx_hold = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        for (int i = 0; i < 6; i++) s_vertex[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset threshold of zero, so only exact zero area degenerates.
        directed_triangle(0, 0, 1, 0, 0, 1);
        directed_triangle(0, 0, 0, 1, 1, 0);
        directed_triangle(0, 0, 0, 0, 0, 0);
        directed_triangle(5, 5, 5, 5, 9, -3);
        directed_triangle(0, 0, 3, 3, -7, -7);
        directed_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
        directed_triangle(-32768, -32768, -32768, 32767, 32767, -32768);
        directed_triangle(-32768, -32768, 32767, -32768, 32767, 32767);
        directed_triangle(32767, 32767, -32768, 32767, -32768, -32768);
        directed_triangle(-32768, 32767, 32767, -32768, 0, 0);
        directed_triangle(32767, 32767, 32767, 32767, -32768, -32768);
        directed_triangle(-1, -1, 0, -1, -1, 0);
        directed_triangle(-32768, 0, 32767, 0, 0, 1);
        directed_triangle(0, 0, 32767, 1, 1, 32767);
        directed_triangle(100, -200, -300, 400, 500, 600);
        directed_triangle(-3, 7, 11, -13, 17, 19);
        drain();

        // Small threshold, with gaps and stalls.
        idle_on = 1'b1;
        write_threshold(34'd1);
        directed_triangle(0, 0, 1, 0, 0, 1);
        directed_triangle(0, 0, 2, 0, 0, 1);
        directed_triangle(0, 0, 0, 1, 1, 0);
        random_triangles(250);
        drain();

        // Largest threshold: everything is degenerate.
        write_threshold({THRESH_W{1'b1}});
        random_triangles(100);
        drain();

        // Threshold above the largest possible twice area; hold the receiver
        // off for a long stretch so the pipeline fills and s_ready drops.
        write_threshold(34'h200000000);
        rx_hold = 300;
        random_triangles(150);
        drain();

        // Random thresholds, mostly small so tiny triangles straddle them.
        for (int p = 0; p < 3; p++) begin
            if (p == 0) write_threshold(THRESH_W'($urandom()));
            else write_threshold(THRESH_W'($urandom_range(0, 600)));
            random_triangles(150);
            drain();
        end

        // Final stretch with no idling on either side.
        write_threshold('0);
        idle_on = 1'b0;
        random_triangles(450);
        drain();

        $display("covered %0d results: %0d counter-clockwise, %0d clockwise, %0d degenerate",
                 sb.checked, sb.n_ccw, sb.n_cw, sb.n_degen);
        $display("thresholds swept from zero to full scale, with stalls and a long hold-off");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
